>>> rtl/bmp_pixel_data_decoder_unit_macros.svh
// Assertion macros shared by the checker files of the BMP pixel decoder.
// Each macro builds one labeled concurrent assertion that is clocked on the
// rising edge and switched off while the active-low reset is asserted.
`ifndef BMP_PIXEL_DATA_DECODER_UNIT_MACROS_SVH
`define BMP_PIXEL_DATA_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPD_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) \
        (ante) |-> (cons)) else $error("bmp decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define BPD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) \
        (ante) |=> (cons)) else $error("bmp decoder check failed");

`endif

>>> rtl/bmp_pdd_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pdd_pkg
// Shared widths, register indexes and packing offsets of the BMP pixel
// data decoder.
// ----------------------------------------------------------------------------
package bmp_pdd_pkg;

    // Configuration port
    localparam int REG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE_PIXELS = 2'd2;

    // Stream payloads
    localparam int COLOR_W    = 8;
    localparam int POS_W      = 12;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 4 * COLOR_W + 2 * POS_W;
    localparam int COLUMN_LSB = 4 * COLOR_W;
    localparam int ROW_LSB    = COLUMN_LSB + POS_W;

    localparam logic [COLOR_W-1:0] OPAQUE_ALPHA = 8'hFF;

    // Byte position inside a pixel
    typedef logic [1:0] phase_t;
    localparam phase_t PH_BLUE  = 2'd0;
    localparam phase_t PH_GREEN = 2'd1;
    localparam phase_t PH_RED   = 2'd2;
    localparam phase_t PH_ALPHA = 2'd3;

endpackage

>>> rtl/bmp_pixel_data_decoder_unit.sv
// ----------------------------------------------------------------------------
// bmp_pixel_data_decoder_unit
// Turns the pixel-array byte stream of a 24-bit or 32-bit BMP image into
// RGBA pixels tagged with column and row.
// ----------------------------------------------------------------------------
// Usage:
// Software parses the file header and writes width, height and pixel size
// through the cfg_* port while the block is idle. Bytes of the pixel array
// enter on the s_* stream, one per transaction; s_tuser marks the first byte
// of an image. Bytes before the first frame start, and after the last pixel
// of an image, are dropped. In 24-bit mode the row padding is skipped.
// Each completed pixel leaves on the m_* stream in the cycle after the
// transaction that carried its last byte; m_tlast flags the last pixel
// (row 0, rightmost column). Rows count down from height-1.
// One byte is taken every cycle while the output is free: the per-byte
// decode is a single layer of logic between the input handshake and the
// output register, so the rate is one transaction per clock.
// When the receiver stalls with a pixel waiting, s_tready drops and the
// counters hold; bytes that produce no pixel still need the output free.
// Reset clears the counters, empties the output register, restores width
// and height 1 in 24-bit mode and waits for a frame start.
// ----------------------------------------------------------------------------
module bmp_pixel_data_decoder_unit
    import bmp_pdd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                 s_tuser,   // [0] frame_start

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
    // [43:32] column, [55:44] row
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast    // image_done
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WSZ = ($clog2(MAX_WIDTH + 1) > REG_W) ? $clog2(MAX_WIDTH + 1) : REG_W;
    localparam int HSZ = ($clog2(MAX_HEIGHT + 1) > REG_W) ? $clog2(MAX_HEIGHT + 1) : REG_W;

    // Configuration registers
    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] height_reg;
    logic             wide_reg;

    // Decoder state
    phase_t           phase_reg,  phase_next;
    logic [COLOR_W-1:0] blue_reg,  blue_next;
    logic [COLOR_W-1:0] green_reg, green_next;
    logic [COLOR_W-1:0] red_reg,   red_next;
    logic [CW-1:0]    col_reg,    col_next;
    logic [RW-1:0]    row_reg,    row_next;
    logic [1:0]       pad_reg,    pad_next;
    logic             fin_reg,    fin_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_last_reg;

    logic [WSZ-1:0]     w_eff;
    logic [HSZ-1:0]     h_eff;
    logic               accept;
    logic               emit;
    logic               row_end;
    logic               last_pix;
    logic [COLOR_W-1:0] pix_red;
    logic [COLOR_W-1:0] pix_alpha;

    // Sizes of zero are taken as one, sizes above the maximum as the maximum.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WSZ'(1);
        else if (WSZ'(width_reg) > WSZ'(MAX_WIDTH))
            w_eff = WSZ'(MAX_WIDTH);
        else
            w_eff = WSZ'(width_reg);

        if (height_reg == '0)
            h_eff = HSZ'(1);
        else if (HSZ'(height_reg) > HSZ'(MAX_HEIGHT))
            h_eff = HSZ'(MAX_HEIGHT);
        else
            h_eff = HSZ'(height_reg);
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        phase_next = phase_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        red_next   = red_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pad_next   = pad_reg;
        fin_next   = fin_reg;
        emit       = 1'b0;
        row_end    = 1'b0;
        last_pix   = 1'b0;
        pix_red    = red_reg;
        pix_alpha  = OPAQUE_ALPHA;

        if (accept)
        begin
            // A frame start restarts the image and is then decoded as blue.
            if (s_tuser)
            begin
                phase_next = PH_BLUE;
                col_next   = '0;
                row_next   = RW'(h_eff - HSZ'(1));
                pad_next   = '0;
                fin_next   = 1'b0;
            end

            row_end  = (WSZ'(col_next) + WSZ'(1)) >= w_eff;
            last_pix = (row_next == '0) && row_end;

            if (!fin_next)
            begin
                if (pad_next != '0)
                begin
                    pad_next = pad_next - 2'd1;
                end
                else
                begin
                    unique case (phase_next) inside
                        PH_BLUE:
                        begin
                            blue_next  = s_tdata;
                            phase_next = PH_GREEN;
                        end
                        PH_GREEN:
                        begin
                            green_next = s_tdata;
                            phase_next = PH_RED;
                        end
                        PH_RED, PH_ALPHA:
                        begin
                            if (wide_reg && phase_next == PH_RED)
                            begin
                                red_next   = s_tdata;
                                phase_next = PH_ALPHA;
                            end
                            else
                            begin
                                // 24-bit pixels end on the red byte.
                                if (wide_reg)
                                begin
                                    pix_alpha = s_tdata;
                                end
                                else
                                begin
                                    red_next = s_tdata;
                                end
                                pix_red    = red_next;
                                phase_next = PH_BLUE;
                                emit       = 1'b1;

                                if (last_pix)
                                begin
                                    fin_next = 1'b1;
                                    col_next = '0;
                                end
                                else if (row_end)
                                begin
                                    col_next = '0;
                                    row_next = row_next - RW'(1);
                                    pad_next = wide_reg ? 2'd0 : w_eff[1:0];
                                end
                                else
                                begin
                                    col_next = col_next + CW'(1);
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_BLUE;
                        end
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        if (accept && emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= REG_W'(1);
            height_reg <= REG_W'(1);
            wide_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:      width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT:     height_reg <= cfg_data;
                CFG_FOUR_BYTE_PIXELS: wide_reg   <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BLUE;
            blue_reg      <= '0;
            green_reg     <= '0;
            red_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            pad_reg       <= '0;
            fin_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            blue_reg      <= blue_next;
            green_reg     <= green_next;
            red_reg       <= red_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pad_reg       <= pad_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    function automatic logic [RW-1:0] row_reg_src();
        return s_tuser ? RW'(h_eff - HSZ'(1)) : row_reg;
    endfunction

    function automatic logic [CW-1:0] col_src();
        return s_tuser ? '0 : col_reg;
    endfunction

    // Payload only, loaded with each new pixel.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= {POS_W'(row_reg_src()), POS_W'(col_src()),
                             pix_alpha, blue_next, green_next, pix_red};
            out_last_reg <= last_pix;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/bmp_pdd_checker.sv
// ----------------------------------------------------------------------------
// bmp_pdd_checker
// Port-level checks of the BMP pixel data decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "bmp_pixel_data_decoder_unit_macros.svh"

module bmp_pdd_checker
    import bmp_pdd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    logic             out_wait;
    logic [POS_W-1:0] out_row;

    assign out_wait = m_tvalid && !m_tready;
    assign out_row  = m_tdata[ROW_LSB +: POS_W];

    // A stalled pixel stays put.
    `BPD_ASSERT_NEXT(a_hold_stalled, clk, rst_n, out_wait, m_tvalid && $stable(m_tdata))
    `BPD_ASSERT_NEXT(a_hold_last, clk, rst_n, out_wait, $stable(m_tlast))

    // The input side is never held off while the output register is empty.
    `BPD_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready)

    // The last pixel of an image lies on the top row.
    `BPD_ASSERT_SAME(a_last_on_top_row, clk, rst_n, m_tvalid && m_tlast, out_row == '0)

    // Nothing follows the last pixel in the next cycle.
    `BPD_ASSERT_NEXT(a_gap_after_last, clk, rst_n, m_tvalid && m_tready && m_tlast, !m_tvalid)

endmodule

bind bmp_pixel_data_decoder_unit bmp_pdd_checker u_bmp_pdd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
